[design/mwr_pkg.sv]
// shared types and constants for the serial eeprom word reader
package mwr_pkg;

  // default sizes of the eeprom word address and data word
  localparam int ADDR_BITS_DEF = 6;
  localparam int DATA_BITS_DEF = 16;

  // fixed field widths
  localparam int WORD_W  = 16;
  localparam int PAIRS_W = 6;
  localparam int PHASE_W = PAIRS_W + 2;

  // idle run length after reset
  localparam logic [PAIRS_W-1:0] IDLE_PAIRS_RESET = 6'd25;

  // request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // command prefix ahead of the address: two zeros, start bit, read opcode
  localparam logic [4:0] CMD_PREFIX = 5'b00110;

  // sequencer stages
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_IDLE1 = 3'd1,
    ST_PRE   = 3'd2,
    ST_CMD   = 3'd3,
    ST_GAP   = 3'd4,
    ST_DATA  = 3'd5,
    ST_IDLE2 = 3'd6
  } stage_t;

  // result of one transfer
  typedef struct packed {
    logic              chip_select;
    logic              serial_clock;
    logic              serial_data_out;
    logic              busy_res;
    logic              word_valid;
    logic [WORD_W-1:0] read_word;
  } res_t;

endpackage

[design/mwr_in_if.sv]
// request channel: tick or start, with address and sampled data pin
interface mwr_in_if #(
  parameter int ADDR_BITS = mwr_pkg::ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [ADDR_BITS-1:0] word_address;
  logic                 data_in_sample;

  modport source (output valid, output req_type, output word_address,
                  output data_in_sample, input ready);
  modport sink (input valid, input req_type, input word_address,
                input data_in_sample, output ready);
endinterface

[design/mwr_out_if.sv]
// result channel: pin levels for one phase plus status and word
interface mwr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      chip_select;
  logic                      serial_clock;
  logic                      serial_data_out;
  logic                      busy_res;
  logic                      word_valid;
  logic [mwr_pkg::WORD_W-1:0] read_word;

  modport source (output valid, output chip_select, output serial_clock,
                  output serial_data_out, output busy_res, output word_valid,
                  output read_word, input ready);
  modport sink (input valid, input chip_select, input serial_clock,
                input serial_data_out, input busy_res, input word_valid,
                input read_word, output ready);
endinterface

[design/mwr_seq.sv]
// read sequencer: state registers and the per-transfer phase decode
module mwr_seq #(
  parameter int ADDR_BITS = mwr_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = mwr_pkg::DATA_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        req_type,
  input  logic [ADDR_BITS-1:0]        word_address,
  input  logic                        data_in_sample,
  input  logic [mwr_pkg::PAIRS_W-1:0] idle_pairs,
  output mwr_pkg::res_t               res
);

  localparam int CMD_BITS = ADDR_BITS + 5;
  localparam logic [mwr_pkg::PHASE_W-1:0] CMD_END  = mwr_pkg::PHASE_W'(2 * CMD_BITS);
  localparam logic [mwr_pkg::PHASE_W-1:0] DATA_END = mwr_pkg::PHASE_W'(2 * DATA_BITS);
  localparam logic [mwr_pkg::PHASE_W-1:0] PRE_END  = mwr_pkg::PHASE_W'(2);

  logic                          busy_r, busy_nxt;
  mwr_pkg::stage_t               stage_r, stage_nxt;
  logic [mwr_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [CMD_BITS-1:0]           cmd_r, cmd_nxt;
  logic [DATA_BITS-1:0]          data_r, data_nxt;
  logic                          pend_r, pend_nxt;

  logic                          is_tick;
  logic                          start_ok;
  logic [mwr_pkg::PHASE_W-1:0]   pairs_end;
  logic [mwr_pkg::PHASE_W-1:0]   phase_inc;
  logic                          idle_last;
  logic                          idle_clk;

  // idle run decode shared by both idle stages
  assign pairs_end = {(mwr_pkg::PHASE_W-1)'(idle_pairs) + (mwr_pkg::PHASE_W-1)'(1), 1'b0};
  assign idle_last = (phase_r >= pairs_end + mwr_pkg::PHASE_W'(1));
  assign idle_clk  = (phase_r >= pairs_end) ? 1'b0 : phase_r[0];
  assign phase_inc = phase_r + mwr_pkg::PHASE_W'(1);
  assign is_tick   = accept && (req_type == mwr_pkg::REQ_TICK) && busy_r;
  assign start_ok  = accept && (req_type == mwr_pkg::REQ_START) && !busy_r;

  // next state
  always_comb begin
    busy_nxt  = busy_r;
    stage_nxt = stage_r;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    data_nxt  = data_r;
    pend_nxt  = pend_r;
    if (start_ok) begin
      cmd_nxt   = {mwr_pkg::CMD_PREFIX, word_address};
      data_nxt  = '0;
      pend_nxt  = 1'b0;
      phase_nxt = '0;
      stage_nxt = mwr_pkg::ST_IDLE1;
      busy_nxt  = 1'b1;
    end else if (is_tick) begin
      if (pend_r) begin
        data_nxt = {data_r[DATA_BITS-2:0], data_in_sample};
        pend_nxt = 1'b0;
      end
      unique case (stage_r)
        mwr_pkg::ST_IDLE1: begin
          if (idle_last) begin
            stage_nxt = mwr_pkg::ST_PRE;
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_inc;
          end
        end
        mwr_pkg::ST_PRE: begin
          phase_nxt = phase_inc;
          if (phase_inc >= PRE_END) begin
            stage_nxt = mwr_pkg::ST_CMD;
            phase_nxt = '0;
          end
        end
        mwr_pkg::ST_CMD: begin
          if (phase_r[0]) cmd_nxt = {cmd_r[CMD_BITS-2:0], 1'b0};
          phase_nxt = phase_inc;
          if (phase_inc >= CMD_END) begin
            stage_nxt = mwr_pkg::ST_GAP;
            phase_nxt = '0;
          end
        end
        mwr_pkg::ST_GAP: begin
          stage_nxt = mwr_pkg::ST_DATA;
          phase_nxt = '0;
        end
        mwr_pkg::ST_DATA: begin
          if (!phase_r[0]) pend_nxt = 1'b1;
          phase_nxt = phase_inc;
          if (phase_inc >= DATA_END) begin
            stage_nxt = mwr_pkg::ST_IDLE2;
            phase_nxt = '0;
          end
        end
        mwr_pkg::ST_IDLE2: begin
          if (idle_last) begin
            busy_nxt  = 1'b0;
            stage_nxt = mwr_pkg::ST_IDLE;
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_inc;
          end
        end
        default: begin
          busy_nxt  = 1'b0;
          stage_nxt = mwr_pkg::ST_IDLE;
          phase_nxt = '0;
        end
      endcase
    end
  end

  // pin levels and status for this transfer
  always_comb begin
    res          = '0;
    res.busy_res = busy_nxt;
    if (is_tick) begin
      unique case (stage_r)
        mwr_pkg::ST_IDLE1: begin
          res.chip_select  = !idle_last;
          res.serial_clock = !idle_last && idle_clk;
        end
        mwr_pkg::ST_PRE: begin
          res.chip_select  = 1'b1;
          res.serial_clock = phase_r[0];
        end
        mwr_pkg::ST_CMD: begin
          res.chip_select     = 1'b1;
          res.serial_clock    = phase_r[0];
          res.serial_data_out = cmd_r[CMD_BITS-1];
        end
        mwr_pkg::ST_GAP: begin
          res.chip_select = 1'b1;
        end
        mwr_pkg::ST_DATA: begin
          res.chip_select  = 1'b1;
          res.serial_clock = !phase_r[0];
        end
        mwr_pkg::ST_IDLE2: begin
          res.chip_select  = !idle_last;
          res.serial_clock = !idle_last && idle_clk;
          res.word_valid   = idle_last;
          res.read_word    = idle_last ? mwr_pkg::WORD_W'(data_nxt) : '0;
        end
        default: begin
          res.chip_select = 1'b0;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      stage_r <= mwr_pkg::ST_IDLE;
      phase_r <= '0;
      cmd_r   <= '0;
      data_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      stage_r <= stage_nxt;
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      data_r  <= data_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

[design/microwire_eeprom_word_reader_top.sv]
// serial eeprom word reader: one phase decode per transfer, registered result
// a result appears in the output register in the cycle after its request transfer
// one request per cycle unless the output stalls; output refills in the cycle it drains
// a read takes 2*(N+1)+2 idle phases twice, 2 preamble, 2*(ADDR_BITS+5) command,
// 1 gap and 2*DATA_BITS data phases, one tick each, N being the idle pair count
// reset (rst_n low, synchronous): sequencer idle, output empty, idle pair count 25
module microwire_eeprom_word_reader_top #(
  parameter int ADDR_BITS = mwr_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = mwr_pkg::DATA_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mwr_in_if.sink                      in_ch,
  mwr_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [mwr_pkg::PAIRS_W-1:0] cfg_wdata
);

  logic [mwr_pkg::PAIRS_W-1:0] idle_pairs_r;
  logic                        out_valid_r;
  mwr_pkg::res_t               out_res_r;
  mwr_pkg::res_t               res;
  logic                        accept;

  // take a request whenever the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // idle run length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_pairs_r <= mwr_pkg::IDLE_PAIRS_RESET;
    end else if (cfg_we) begin
      idle_pairs_r <= cfg_wdata;
    end
  end

  mwr_seq #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .req_type       (in_ch.req_type),
    .word_address   (in_ch.word_address),
    .data_in_sample (in_ch.data_in_sample),
    .idle_pairs     (idle_pairs_r),
    .res            (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.chip_select     = out_res_r.chip_select;
  assign out_ch.serial_clock    = out_res_r.serial_clock;
  assign out_ch.serial_data_out = out_res_r.serial_data_out;
  assign out_ch.busy_res        = out_res_r.busy_res;
  assign out_ch.word_valid      = out_res_r.word_valid;
  assign out_ch.read_word       = out_res_r.read_word;

endmodule
